/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the 2x2 eigen solver.
// Depends on nothing; users provide clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that is also live during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/ees_pkg.sv */
// Types and constants for the 2x2 real eigen solver pipeline.
// No dependencies.
`default_nettype none
package ees_pkg;
  localparam int DW    = 32;
  localparam int FB    = 16;
  localparam int THRW  = 16;
  localparam int DDW   = 68;        // discriminant width
  localparam int QW    = DDW / 2;   // square root width, one bit per cell
  localparam int REMW  = QW + 3;
  localparam int NCELL = QW;
  localparam int NFRONT = 3;
  localparam int NST   = NFRONT + NCELL + 2;

  typedef enum logic [1:0] {
    K_DIAG  = 2'd0,
    K_SMALL = 2'd1,
    K_ROOT  = 2'd2,
    K_CPLX  = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [DW-1:0] xx;
    logic signed [DW-1:0] xy;
    logic signed [DW-1:0] yx;
    logic signed [DW-1:0] yy;
    logic signed [DW:0]   m;
    logic                 xys;
    logic                 yxs;
    kind_t                kind;
  } side_t;

  typedef struct packed {
    logic [DDW-1:0]  d;
    logic [REMW-1:0] rem;
    logic [QW-1:0]   root;
  } sq_t;
endpackage
`default_nettype wire

/* hdl/ees_front.sv */
// Front stages: products and trace, determinant, discriminant and path choice.
// Depends on ees_pkg.
`default_nettype none
module ees_front (
  input  wire logic                        clk,
  input  wire logic [ees_pkg::NFRONT-1:0]  en,
  input  wire logic [ees_pkg::THRW-1:0]    thr,
  input  wire logic signed [ees_pkg::DW-1:0] a_xx,
  input  wire logic signed [ees_pkg::DW-1:0] a_xy,
  input  wire logic signed [ees_pkg::DW-1:0] a_yx,
  input  wire logic signed [ees_pkg::DW-1:0] a_yy,
  output      ees_pkg::side_t              side_o,
  output      logic [ees_pkg::DDW-1:0]     d_o
);
  localparam int PW = 2 * ees_pkg::DW;

  ees_pkg::side_t s0_r, s1_r, s2_r;
  logic signed [PW-1:0]        pa_r, pb_r;
  logic signed [PW+1:0]        mm_r;
  logic signed [PW:0]          p_r;
  logic [ees_pkg::DDW-1:0]     d_r;
  ees_pkg::side_t              s0_nxt, s2_nxt;
  logic [ees_pkg::DW-1:0]      mxy, myx;
  logic signed [PW+1:0]        m66;
  logic [PW:0]                 pm;
  logic [PW:0]                 lim;
  logic signed [ees_pkg::DDW-1:0] dd;

  always_comb begin
    mxy = a_xy[ees_pkg::DW-1] ? ees_pkg::DW'(-a_xy) : a_xy;
    myx = a_yx[ees_pkg::DW-1] ? ees_pkg::DW'(-a_yx) : a_yx;
    s0_nxt.xx   = a_xx;
    s0_nxt.xy   = a_xy;
    s0_nxt.yx   = a_yx;
    s0_nxt.yy   = a_yy;
    s0_nxt.m    = (ees_pkg::DW+1)'(a_xx) + (ees_pkg::DW+1)'(a_yy);
    s0_nxt.xys  = mxy < ees_pkg::DW'(thr);
    s0_nxt.yxs  = myx < ees_pkg::DW'(thr);
    s0_nxt.kind = ees_pkg::K_DIAG;
  end

  assign m66 = (PW+2)'(s0_r.m);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_r <= s0_nxt;
      pa_r <= PW'(a_xx) * PW'(a_yy);
      pb_r <= PW'(a_xy) * PW'(a_yx);
    end
    if (en[1]) begin
      s1_r <= s0_r;
      mm_r <= m66 * m66;
      p_r  <= (PW+1)'(pa_r) - (PW+1)'(pb_r);
    end
    if (en[2]) begin
      s2_r <= s2_nxt;
      d_r  <= dd;
    end
  end

  always_comb begin
    pm  = p_r[PW] ? (PW+1)'(-p_r) : p_r;
    lim = (PW+1)'({thr, {ees_pkg::FB{1'b0}}});
    dd  = ees_pkg::DDW'(mm_r) - (ees_pkg::DDW'(p_r) <<< 2);
    s2_nxt = s1_r;
    if (s1_r.xys && s1_r.yxs) begin
      s2_nxt.kind = ees_pkg::K_DIAG;
    end else if (pm < lim) begin
      s2_nxt.kind = ees_pkg::K_SMALL;
    end else if (dd[ees_pkg::DDW-1] || dd == '0) begin
      s2_nxt.kind = ees_pkg::K_CPLX;
    end else begin
      s2_nxt.kind = ees_pkg::K_ROOT;
    end
  end

  assign side_o = s2_r;
  assign d_o    = d_r;
endmodule
`default_nettype wire

/* hdl/ees_sqrt_cell.sv */
// One digit cell of the square root chain: takes two bits of the radicand.
// Depends on ees_pkg.
`default_nettype none
module ees_sqrt_cell (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire ees_pkg::sq_t   sq_i,
  input  wire ees_pkg::side_t side_i,
  output      ees_pkg::sq_t   sq_o,
  output      ees_pkg::side_t side_o
);
  ees_pkg::sq_t   sq_r, sq_nxt;
  ees_pkg::side_t side_r;
  logic [ees_pkg::REMW-1:0] rem_w, trial;
  logic ge;

  always_comb begin
    rem_w = {sq_i.rem[ees_pkg::REMW-3:0], sq_i.d[ees_pkg::DDW-1 -: 2]};
    trial = {1'b0, sq_i.root, 2'b01};
    ge    = rem_w >= trial;
    sq_nxt.d    = {sq_i.d[ees_pkg::DDW-3:0], 2'b00};
    sq_nxt.rem  = ge ? rem_w - trial : rem_w;
    sq_nxt.root = {sq_i.root[ees_pkg::QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r   <= sq_nxt;
      side_r <= side_i;
    end
  end

  assign sq_o   = sq_r;
  assign side_o = side_r;
endmodule
`default_nettype wire

/* hdl/ees_back.sv */
// Back stages: eigenvalues with sort and clipping, then eigenvectors.
// Depends on ees_pkg.
`default_nettype none
module ees_back (
  input  wire logic                        clk,
  input  wire logic [1:0]                  en,
  input  wire logic [ees_pkg::THRW-1:0]    thr,
  input  wire ees_pkg::side_t              side_i,
  input  wire logic [ees_pkg::QW-1:0]      q,
  output      logic [6*ees_pkg::DW-1:0]    data_o,
  output      logic [1:0]                  flags_o
);
  localparam int EW = ees_pkg::DW + 4;

  function automatic logic signed [ees_pkg::DW:0] satw(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] hi, lo;
    hi = EW'({1'b0, {(ees_pkg::DW-1){1'b1}}});
    lo = -hi - EW'(1);
    if (v > hi)      satw = {1'b1, hi[ees_pkg::DW-1:0]};
    else if (v < lo) satw = {1'b1, lo[ees_pkg::DW-1:0]};
    else             satw = {1'b0, v[ees_pkg::DW-1:0]};
  endfunction

  ees_pkg::side_t s_r;
  logic signed [ees_pkg::DW-1:0] lo_r, hi_r;
  logic fl_r, cplx_r;
  logic [6*ees_pkg::DW-1:0] data_r;
  logic [1:0] flags_r;

  logic signed [EW-1:0] ms, qs, e1, e2, t;
  logic signed [ees_pkg::DW:0] slo, shi;

  always_comb begin
    ms = EW'(side_i.m);
    qs = EW'($signed({2'b00, q}));
    e1 = '0;
    e2 = '0;
    t  = '0;
    case (side_i.kind)
      ees_pkg::K_DIAG: begin
        e1 = EW'(side_i.xx);
        e2 = EW'(side_i.yy);
      end
      ees_pkg::K_SMALL: begin
        e2 = ms;
      end
      ees_pkg::K_ROOT: begin
        e1 = (ms - qs) >>> 1;
        e2 = (ms + qs) >>> 1;
      end
      default: begin
        e1 = '0;
        e2 = '0;
      end
    endcase
    if (e1 > e2) begin
      t  = e1;
      e1 = e2;
      e2 = t;
    end
    slo = satw(e1);
    shi = satw(e2);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s_r    <= side_i;
      lo_r   <= slo[ees_pkg::DW-1:0];
      hi_r   <= shi[ees_pkg::DW-1:0];
      fl_r   <= slo[ees_pkg::DW] | shi[ees_pkg::DW];
      cplx_r <= side_i.kind == ees_pkg::K_CPLX;
    end
  end

  logic signed [EW-1:0] vx [2], vy [2];
  logic signed [ees_pkg::DW:0] svx [2], svy [2];
  logic signed [ees_pkg::DW-1:0] lam [2];
  logic signed [ees_pkg::DW-1:0] mn;
  logic signed [EW-1:0] thr_s;
  logic [6*ees_pkg::DW-1:0] data_nxt;
  logic vfl;

  always_comb begin
    lam[0] = lo_r;
    lam[1] = hi_r;
    mn     = (s_r.xx < s_r.yy) ? s_r.xx : s_r.yy;
    thr_s  = EW'($signed({1'b0, thr}));
    vfl    = 1'b0;
    for (int k = 0; k < 2; k++) begin
      vx[k] = '0;
      vy[k] = '0;
      if (EW'(lam[k]) >= thr_s) begin
        if (s_r.xys && s_r.yxs) begin
          if (lam[k] > mn) vx[k] = EW'(1) <<< ees_pkg::FB;
          else             vy[k] = EW'(1) <<< ees_pkg::FB;
        end else if (s_r.xys) begin
          vx[k] = EW'(lam[k]) - EW'(s_r.yy);
          vy[k] = EW'(s_r.yx);
        end else begin
          vx[k] = EW'(s_r.xy);
          vy[k] = EW'(lam[k]) - EW'(s_r.yy);
        end
      end
      svx[k] = satw(vx[k]);
      svy[k] = satw(vy[k]);
      vfl = vfl | svx[k][ees_pkg::DW] | svy[k][ees_pkg::DW];
    end
    data_nxt = {svy[1][ees_pkg::DW-1:0], svx[1][ees_pkg::DW-1:0],
                svy[0][ees_pkg::DW-1:0], svx[0][ees_pkg::DW-1:0], hi_r, lo_r};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      if (cplx_r) begin
        data_r  <= '0;
        flags_r <= 2'b01;
      end else begin
        data_r  <= data_nxt;
        flags_r <= {fl_r | vfl, 1'b0};
      end
    end
  end

  assign data_o  = data_r;
  assign flags_o = flags_r;
endmodule
`default_nettype wire

/* hdl/eigen_2x2_real_solver_core.sv */
// Real eigenvalues and eigenvectors of a 2x2 signed Q16.16 matrix. A new
// request is taken every cycle when the output side keeps up. The depth is
// set by the square root, a chain of 34 cells that settle one root bit each,
// behind three stages for products, determinant and discriminant and ahead
// of two for eigenvalues and eigenvectors. Stages hand on independently, so
// empty slots fill while a result waits. The user must write small_threshold
// through cfg_wr_en only when idle; the core does not enforce this.
`default_nettype none
`include "assert_macros.svh"
module eigen_2x2_real_solver_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic [15:0]   cfg_wr_data,
  input  wire logic          in_tvalid,
  output      logic          in_tready,
  input  wire logic [127:0]  in_tdata,   // a_xx, a_xy, a_yx, a_yy
  output      logic          out_tvalid,
  input  wire logic          out_tready,
  output      logic [191:0]  out_tdata,  // eig_low, eig_high, vec_low_x, vec_low_y,
                                         // vec_high_x, vec_high_y
  output      logic [1:0]    out_tuser   // complex_error, saturated
);
  localparam int N = ees_pkg::NST;
  localparam int F = ees_pkg::NFRONT;
  localparam int C = ees_pkg::NCELL;
  localparam int DW = ees_pkg::DW;

  logic [ees_pkg::THRW-1:0] thr_r;
  logic [N-1:0] vld_r, vld_nxt, en;

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= ees_pkg::THRW'(1);
    else if (cfg_wr_en) thr_r <= cfg_wr_data;
  end

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[N-1] = !vld_r[N-1] || out_tready;
    for (int i = N-2; i >= 0; i--) en[i] = !vld_r[i] || en[i+1];
    vld_nxt[0] = en[0] ? in_tvalid : vld_r[0];
    for (int i = 1; i < N; i++) vld_nxt[i] = en[i] ? vld_r[i-1] : vld_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= vld_nxt;
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[N-1];

  ees_pkg::side_t side [C+1];
  ees_pkg::sq_t   sq   [C+1];
  logic [ees_pkg::DDW-1:0] d;

  ees_front u_front (
    .clk    (clk),
    .en     (en[F-1:0]),
    .thr    (thr_r),
    .a_xx   ($signed(in_tdata[DW-1:0])),
    .a_xy   ($signed(in_tdata[2*DW-1:DW])),
    .a_yx   ($signed(in_tdata[3*DW-1:2*DW])),
    .a_yy   ($signed(in_tdata[4*DW-1:3*DW])),
    .side_o (side[0]),
    .d_o    (d)
  );

  always_comb begin
    sq[0].d    = d;
    sq[0].rem  = '0;
    sq[0].root = '0;
  end

  for (genvar g = 0; g < C; g++) begin : g_cell
    ees_sqrt_cell u_cell (
      .clk    (clk),
      .en     (en[F+g]),
      .sq_i   (sq[g]),
      .side_i (side[g]),
      .sq_o   (sq[g+1]),
      .side_o (side[g+1])
    );
  end

  ees_back u_back (
    .clk     (clk),
    .en      (en[N-1:N-2]),
    .thr     (thr_r),
    .side_i  (side[C]),
    .q       (sq[C].root),
    .data_o  (out_tdata),
    .flags_o (out_tuser)
  );

  `ASSERT_CLK(a_cplx_zero, out_tvalid && out_tuser[0] |-> out_tdata == '0 && !out_tuser[1],
    "complex result carries data")
  `ASSERT_CLK(a_sorted, out_tvalid && !out_tuser[0] |->
    $signed(out_tdata[DW-1:0]) <= $signed(out_tdata[2*DW-1:DW]), "eigenvalues out of order")
  `ASSERT_CLK(a_ready_free, !vld_r[N-1] |-> in_tready, "input stalled with empty output")
  `ASSERT_CLK(a_enter, in_tvalid && in_tready |=> vld_r[0], "accepted request lost")
endmodule
`default_nettype wire

/* tb/sv/eigen_2x2_real_solver_core_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for eigen_2x2_real_solver_core: directed matrices, then random ones,
// checked against typed expectations or a wide-integer eigen predictor. Depends only on the RTL of the core.
module eigen_2x2_real_solver_core_test;

  typedef struct packed {
    logic [31:0] eig_low;
    logic [31:0] eig_high;
    logic [31:0] vec_low_x;
    logic [31:0] vec_low_y;
    logic [31:0] vec_high_x;
    logic [31:0] vec_high_y;
    logic        complex_error;
    logic        saturated;
  } eig_res_t;

  typedef struct {
    logic [31:0] xx, xy, yx, yy;
    logic        typed;
    eig_res_t    res;
  } matrix_row_t;

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] VMAX = 32'h7fff_ffff;
  localparam logic [31:0] VMIN = 32'h8000_0000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_wr_en = 1'b0;
  logic [15:0]   cfg_wr_data = '0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [127:0]  in_tdata = '0;   // a_xx, a_xy, a_yx, a_yy
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [191:0]  out_tdata;      // eig_low, eig_high, vec_low_x, vec_low_y, vec_high_x, vec_high_y
  logic [1:0]    out_tuser;      // complex_error, saturated

  // typed expectation travelling beside the request being offered
  logic          req_typed = 1'b0;
  eig_res_t      req_res = '0;

  logic [15:0]   thr_shadow = 16'd1;
  eig_res_t      pending_q[$];
  int            mismatches = 0;
  int            received = 0;
  bit            no_idle = 1'b0;
  bit            hold_done = 1'b0;
  matrix_row_t   rows[$];

  eigen_2x2_real_solver_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] clip32(input logic signed [127:0] v, inout logic f);
    if (v > $signed(128'sh7fff_ffff)) begin
      f = 1'b1;
      return VMAX;
    end
    if (v < -$signed(128'sh8000_0000)) begin
      f = 1'b1;
      return VMIN;
    end
    return v[31:0];
  endfunction

  function automatic void eigen_vector(input logic signed [127:0] lam, xx, xy, yx, yy, thr,
                                       input logic xys, yxs,
                                       output logic [31:0] vx, vy, inout logic f);
    logic signed [127:0] x, y;
    x = 0;
    y = 0;
    if (lam >= thr) begin
      if (xys && yxs) begin
        if (lam > ((xx < yy) ? xx : yy)) x = 128'sd1 <<< 16;
        else y = 128'sd1 <<< 16;
      end else if (xys) begin
        x = lam - yy;
        y = yx;
      end else begin
        x = xy;
        y = lam - yy;
      end
    end
    vx = clip32(x, f);
    vy = clip32(y, f);
  endfunction

  function automatic eig_res_t solve_eigen(input logic [127:0] d, input logic [15:0] thr16);
    logic signed [127:0] xx, xy, yx, yy, thr, m, p, pm, disc, e1, e2, tmp;
    logic [127:0] root, cand;
    logic xys, yxs, f;
    eig_res_t res;
    xx = $signed(d[31:0]);
    xy = $signed(d[63:32]);
    yx = $signed(d[95:64]);
    yy = $signed(d[127:96]);
    thr = {112'd0, thr16};
    xys = ((xy < 0) ? -xy : xy) < thr;
    yxs = ((yx < 0) ? -yx : yx) < thr;
    res = '0;
    f = 1'b0;
    if (xys && yxs) begin
      e1 = xx;
      e2 = yy;
    end else begin
      m = xx + yy;
      p = xx * yy - xy * yx;
      pm = (p < 0) ? -p : p;
      if (pm < (thr <<< 16)) begin
        e1 = 0;
        e2 = m;
      end else begin
        disc = m * m - 4 * p;
        if (disc <= 0) begin
          res.complex_error = 1'b1;
          return res;
        end
        root = 0;
        for (int b = 40; b >= 0; b--) begin
          cand = root | (128'd1 << b);
          if (cand * cand <= disc) root = cand;
        end
        e1 = (m - $signed(root)) >>> 1;
        e2 = (m + $signed(root)) >>> 1;
      end
    end
    if (e1 > e2) begin
      tmp = e1;
      e1 = e2;
      e2 = tmp;
    end
    res.eig_low = clip32(e1, f);
    res.eig_high = clip32(e2, f);
    eigen_vector($signed(res.eig_low), xx, xy, yx, yy, thr, xys, yxs,
                 res.vec_low_x, res.vec_low_y, f);
    eigen_vector($signed(res.eig_high), xx, xy, yx, yy, thr, xys, yxs,
                 res.vec_high_x, res.vec_high_y, f);
    res.saturated = f;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] span(input int unsigned n);
    return $urandom_range(0, 2 * n) - n;
  endfunction

  task automatic send_matrix(input logic [31:0] xx, xy, yx, yy,
                             input logic typed, input eig_res_t res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {yy, yx, xy, xx};
    req_typed <= typed;
    req_res <= res;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    thr_shadow = v;
  endtask

  task automatic send_random(input int count);
    logic [31:0] a, b, c, e;
    int unsigned t;
    for (int i = 0; i < count; i++) begin
      t = thr_shadow;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          a = $urandom; b = $urandom; c = $urandom; e = $urandom;
        end
        3, 4: begin
          a = span(1 << 24); e = span(1 << 24); b = span(1 << 20); c = b;
        end
        5: begin
          a = $urandom; e = $urandom;
          b = (t == 0) ? 32'd0 : span(t - 1); c = (t == 0) ? 32'd0 : span(t - 1);
        end
        6: begin
          a = span(2 * t + 4); b = span(2 * t + 4); c = span(2 * t + 4); e = span(2 * t + 4);
        end
        7: begin
          a = span(1 << 22); e = span(1 << 22); c = span(1 << 22);
          b = (t == 0) ? 32'd0 : span(t - 1);
        end
        8: begin
          a = $urandom_range(0, 1) ? VMAX : VMIN; e = $urandom_range(0, 1) ? VMAX : VMIN;
          b = $urandom_range(0, 1) ? VMAX : $urandom; c = $urandom_range(0, 1) ? VMIN : $urandom;
        end
        default: begin
          a = span(1 << 20); b = span(1 << 20); c = a; e = b;
        end
      endcase
      send_matrix(a, b, c, e, 1'b0, '0);
    end
  endtask

  function automatic void add_row(input logic [31:0] xx, xy, yx, yy,
                                  input logic typed, input eig_res_t res);
    matrix_row_t r;
    r.xx = xx; r.xy = xy; r.yx = yx; r.yy = yy;
    r.typed = typed;
    r.res = res;
    rows.push_back(r);
  endfunction

  // accept side: queue an expectation for each accepted request, typed or predicted
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      if (req_typed) pending_q.push_back(req_res);
      else pending_q.push_back(solve_eigen(in_tdata, thr_shadow));
    end
  end

  // result side: compare against the oldest expectation
  always @(posedge clk) begin
    eig_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[31:0], out_tdata[63:32], out_tdata[95:64], out_tdata[127:96],
             out_tdata[159:128], out_tdata[191:160], out_tuser[0], out_tuser[1]};
      received <= received + 1;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request outstanding: %h", got);
      end else begin
        want = pending_q.pop_front();
        if (got.eig_low !== want.eig_low || got.eig_high !== want.eig_high ||
            got.vec_low_x !== want.vec_low_x || got.vec_low_y !== want.vec_low_y ||
            got.vec_high_x !== want.vec_high_x || got.vec_high_y !== want.vec_high_y ||
            got.complex_error !== want.complex_error || got.saturated !== want.saturated)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected eig %h %h vec %h %h %h %h cplx %b sat %b\n%s%h %h vec %h %h %h %h cplx %b sat %b",
                     want.eig_low, want.eig_high, want.vec_low_x, want.vec_low_y,
                     want.vec_high_x, want.vec_high_y, want.complex_error, want.saturated,
                     "          actual eig ", got.eig_low, got.eig_high, got.vec_low_x,
                     got.vec_low_y, got.vec_high_x, got.vec_high_y, got.complex_error,
                     got.saturated);
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off so the pipeline backs up
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && received >= 150) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    eig_res_t r;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    r = '0;
    add_row(0, 0, 0, 0, 1'b1, r);
    r = '0;
    r.eig_low = ONE; r.eig_high = 2 * ONE; r.vec_low_y = ONE; r.vec_high_x = ONE;
    add_row(ONE, 0, 0, 2 * ONE, 1'b1, r);
    r = '0;
    r.complex_error = 1'b1;
    add_row(0, ONE, -ONE, 0, 1'b1, r);
    add_row(VMAX, VMAX, VMAX, VMAX, 1'b0, '0);
    add_row(VMIN, VMIN, VMIN, VMIN, 1'b0, '0);
    add_row(VMAX, 0, 0, VMAX, 1'b0, '0);
    add_row(VMIN, 0, 0, VMIN, 1'b0, '0);
    add_row(VMIN, VMAX, VMIN, VMAX, 1'b0, '0);
    add_row(VMAX, VMIN, VMAX, VMIN, 1'b0, '0);
    add_row(VMAX, VMAX, VMIN, VMIN, 1'b0, '0);
    add_row(ONE, ONE, 0, ONE, 1'b0, '0);          // repeated root
    add_row(1, 1, 1, 1, 1'b0, '0);                // determinant below threshold
    add_row(3 * ONE, 0, 5 * ONE, ONE, 1'b0, '0);  // only a_xy small
    add_row(3 * ONE, 5 * ONE, 0, ONE, 1'b0, '0);  // only a_yx small
    add_row(2 * ONE, ONE, ONE, 2 * ONE, 1'b0, '0);
    add_row(-2 * ONE, ONE, ONE, -3 * ONE, 1'b0, '0); // negative eigenvalues, zero vectors
    add_row(5, 1, -1, 7, 1'b0, '0);
    add_row(-ONE, 0, 0, ONE, 1'b0, '0);
    add_row(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 1'b0, '0);
    foreach (rows[i])
      send_matrix(rows[i].xx, rows[i].xy, rows[i].yx, rows[i].yy, rows[i].typed, rows[i].res);

    send_random(300);
    write_threshold(16'd0);
    send_random(300);
    write_threshold(16'hffff);
    no_idle = 1'b1;
    send_random(300);
    no_idle = 1'b0;
    write_threshold(16'($urandom_range(0, 16'hffff)));
    send_random(300);
    write_threshold(16'd1);
    send_random(300);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/ees_pkg.sv
hdl/ees_front.sv
hdl/ees_sqrt_cell.sv
hdl/ees_back.sv
hdl/eigen_2x2_real_solver_core.sv
tb/sv/eigen_2x2_real_solver_core_test.sv
